>>> hdl/mshz_pkg.sv
// Shared opcodes, decode codes and pipeline stage types for the decode and hazard block.
package mshz_pkg;

   localparam int WordWidth = 32;
   localparam int RegWidth  = 5;

   // Major opcodes, bits 31..26
   localparam logic [5:0] OP_RTYPE = 6'b000000;
   localparam logic [5:0] OP_LOAD  = 6'b100011;
   localparam logic [5:0] OP_STORE = 6'b101011;
   localparam logic [5:0] OP_BEQ   = 6'b000100;
   localparam logic [5:0] OP_BNE   = 6'b000101;
   localparam logic [5:0] OP_J     = 6'b000010;
   localparam logic [5:0] OP_JAL   = 6'b000011;
   localparam logic [5:0] OP_LUI   = 6'b001111;

   // Function codes, bits 5..0
   localparam logic [5:0] FN_JR  = 6'b001000;
   localparam logic [5:0] FN_ADD = 6'b100000;
   localparam logic [5:0] FN_SUB = 6'b100010;
   localparam logic [5:0] FN_OR  = 6'b100101;
   localparam logic [5:0] FN_SLT = 6'b101010;
   localparam logic [5:0] FN_AND = 6'b100100;
   localparam logic [5:0] FN_SLL = 6'b000000;
   localparam logic [5:0] FN_SRL = 6'b000010;

   typedef enum logic [3:0] {
      CLS_NOOP  = 4'd0,
      CLS_RTYPE = 4'd1,
      CLS_JR    = 4'd2,
      CLS_LOAD  = 4'd3,
      CLS_STORE = 4'd4,
      CLS_BEQ   = 4'd5,
      CLS_BNE   = 4'd6,
      CLS_J     = 4'd7,
      CLS_JAL   = 4'd8,
      CLS_LUI   = 4'd9,
      CLS_OTHER = 4'd10
   } class_type;

   typedef enum logic [3:0] {
      ALU_ADD     = 4'd0,
      ALU_SUB     = 4'd1,
      ALU_OR      = 4'd2,
      ALU_SLT     = 4'd3,
      ALU_AND     = 4'd4,
      ALU_NOOP    = 4'd5,
      ALU_SLL     = 4'd6,
      ALU_SRL     = 4'd7,
      ALU_UNKNOWN = 4'd8
   } alu_type;

   typedef struct packed {
      class_type cls;
      alu_type   alu;
      logic      nonzero;
   } dec_type;

   // Stage 1: both words decoded
   typedef struct packed {
      logic [WordWidth-1:0] later;
      dec_type              later_dec;
      dec_type              earlier_dec;
      logic [RegWidth-1:0]  earlier_rt;
      logic [RegWidth-1:0]  earlier_rd;
   } s1_type;

   // Stage 2: source reads and writer resolved
   typedef struct packed {
      logic [WordWidth-1:0] later;
      class_type            cls;
      alu_type              alu;
      logic                 reads_rs;
      logic                 reads_rt;
      logic                 writer_valid;
      logic [RegWidth-1:0]  writer_reg;
      logic                 both_nonzero;
   } s2_type;

   // Result beat, last field in the lowest bits
   typedef struct packed {
      logic [5:0]           pad;
      logic                 hazard;
      logic [RegWidth-1:0]  writer_reg;
      logic                 writer_valid;
      logic                 reads_rt;
      logic                 reads_rs;
      logic [25:0]          jump_index;
      logic [15:0]          imm_field;
      logic [RegWidth-1:0]  rd_field;
      logic [RegWidth-1:0]  rt_field;
      logic [RegWidth-1:0]  rs_field;
      alu_type              alu_op;
      class_type            instr_class;
   } rsp_type;

   // Hazard compare inputs
   typedef struct packed {
      logic                reads_rs;
      logic                reads_rt;
      logic                writer_valid;
      logic                both_nonzero;
      logic [RegWidth-1:0] rs;
      logic [RegWidth-1:0] rt;
      logic [RegWidth-1:0] writer_reg;
   } hzd_in_type;

endpackage

>>> hdl/mips_subset_decode_hazard_check.sv
// Top level: three-stage decode and hazard check pipeline.
//
//   channel | beat fields (tdata, low bit first)                         | bits
//   req     | later_instruction, earlier_instruction                     | 64
//   rsp     | instr_class, alu_op, rs, rt, rd, imm, jump_index, reads_rs,| 80
//           | reads_rt, writer_valid, writer_reg, hazard, zero pad       |
//
// One instruction pair enters per cycle unless the pipeline is stalled; each result passes
// decode, operand/writer resolve, then hazard compare into the output register.
// Each stage holds its beat while the stage after it is full and stalled; an empty
// stage takes a new beat even when the output is stalled.
// Reset empties all three stages; the payload registers are not cleared.
module mips_subset_decode_hazard_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [31:0] later_instruction, [63:32] earlier_instruction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata   // instr_class[3:0], alu_op[7:4], rs_field[12:8],
                                   // rt_field[17:13], rd_field[22:18], imm_field[38:23],
                                   // jump_index[64:39], reads_rs[65], reads_rt[66],
                                   // writer_valid[67], writer_reg[72:68], hazard[73]
);
   import mshz_pkg::*;

   logic [WordWidth-1:0] later_word;
   logic [WordWidth-1:0] earlier_word;
   dec_type              later_dec;
   dec_type              earlier_dec;

   logic       v1_ff, v2_ff, v3_ff;
   logic       rdy1, rdy2, rdy3;
   s1_type     s1_ff, s1_in;
   s2_type     s2_ff, s2_in;
   rsp_type    out_ff, out_in;
   hzd_in_type hzd_in;
   logic       hazard;
   logic       is_shift;

   assign later_word   = req_tdata[31:0];
   assign earlier_word = req_tdata[63:32];

   // Stage readiness: a stage moves when it is empty or its successor moves
   assign rdy3       = !v3_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   mshz_decode u_dec_later (
      .word (later_word),
      .dec  (later_dec)
   );

   mshz_decode u_dec_earlier (
      .word (earlier_word),
      .dec  (earlier_dec)
   );

   always_comb begin
      s1_in.later       = later_word;
      s1_in.later_dec   = later_dec;
      s1_in.earlier_dec = earlier_dec;
      s1_in.earlier_rt  = earlier_word[20:16];
      s1_in.earlier_rd  = earlier_word[15:11];
   end

   // Stage 2: which sources the later word reads, which register the earlier writes
   assign is_shift = (s1_ff.later[5:0] == FN_SLL) || (s1_ff.later[5:0] == FN_SRL);

   always_comb begin
      s2_in.later        = s1_ff.later;
      s2_in.cls          = s1_ff.later_dec.cls;
      s2_in.alu          = s1_ff.later_dec.alu;
      s2_in.reads_rs     = 1'b0;
      s2_in.reads_rt     = 1'b0;
      s2_in.writer_valid = 1'b0;
      s2_in.writer_reg   = '0;
      s2_in.both_nonzero = s1_ff.later_dec.nonzero && s1_ff.earlier_dec.nonzero;
      unique case (s1_ff.later_dec.cls)
         CLS_RTYPE: begin
            s2_in.reads_rs = !is_shift;
            s2_in.reads_rt = 1'b1;
         end
         CLS_STORE, CLS_BEQ, CLS_BNE: begin
            s2_in.reads_rs = 1'b1;
            s2_in.reads_rt = 1'b1;
         end
         CLS_LOAD, CLS_JR: begin
            s2_in.reads_rs = 1'b1;
         end
         default: begin
         end
      endcase
      unique case (s1_ff.earlier_dec.cls)
         CLS_RTYPE: begin
            s2_in.writer_valid = 1'b1;
            s2_in.writer_reg   = s1_ff.earlier_rd;
         end
         CLS_LOAD, CLS_LUI: begin
            s2_in.writer_valid = 1'b1;
            s2_in.writer_reg   = s1_ff.earlier_rt;
         end
         default: begin
         end
      endcase
   end

   // Stage 3: hazard compare and result assembly
   always_comb begin
      hzd_in.reads_rs     = s2_ff.reads_rs;
      hzd_in.reads_rt     = s2_ff.reads_rt;
      hzd_in.writer_valid = s2_ff.writer_valid;
      hzd_in.both_nonzero = s2_ff.both_nonzero;
      hzd_in.rs           = s2_ff.later[25:21];
      hzd_in.rt           = s2_ff.later[20:16];
      hzd_in.writer_reg   = s2_ff.writer_reg;
   end

   mshz_hazard u_hazard (
      .hzd_in (hzd_in),
      .hazard (hazard)
   );

   always_comb begin
      out_in.pad          = '0;
      out_in.hazard       = hazard;
      out_in.writer_reg   = s2_ff.writer_reg;
      out_in.writer_valid = s2_ff.writer_valid;
      out_in.reads_rt     = s2_ff.reads_rt;
      out_in.reads_rs     = s2_ff.reads_rs;
      out_in.jump_index   = s2_ff.later[25:0];
      out_in.imm_field    = s2_ff.later[15:0];
      out_in.rd_field     = s2_ff.later[15:11];
      out_in.rt_field     = s2_ff.later[20:16];
      out_in.rs_field     = s2_ff.later[25:21];
      out_in.alu_op       = s2_ff.alu;
      out_in.instr_class  = s2_ff.cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Payload advances only with a valid beat behind it
   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) s1_ff  <= s1_in;
      if (rdy2 && v1_ff)      s2_ff  <= s2_in;
      if (rdy3 && v2_ff)      out_ff <= out_in;
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = out_ff;

`ifndef NO_ASSERTIONS
   a_hazard_needs_writer : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!out_ff.hazard || out_ff.writer_valid))
      else $error("hazard raised without a writer");

   a_hazard_needs_read : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!out_ff.hazard || out_ff.reads_rs || out_ff.reads_rt))
      else $error("hazard raised without a source read");

   a_no_writer_zero_reg : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_ff.writer_valid) |-> (out_ff.writer_reg == '0))
      else $error("writer register set with no writer");

   a_stage2_fill : assert property (@(posedge clock) disable iff (reset)
      (v1_ff && rdy2) |=> v2_ff)
      else $error("stage 1 beat lost on advance");
`endif

endmodule

>>> hdl/mshz_decode.sv
// Instruction word decoder: class, ALU operation and zero-word flag.
module mshz_decode (
   input  logic [mshz_pkg::WordWidth-1:0] word,
   output mshz_pkg::dec_type              dec
);
   import mshz_pkg::*;

   logic [5:0] opcode;
   logic [5:0] funct;
   class_type  cls;
   alu_type    alu;

   assign opcode = word[31:26];
   assign funct  = word[5:0];

   always_comb begin
      if (word == '0) begin
         cls = CLS_NOOP;
      end else begin
         unique case (opcode)
            OP_RTYPE: cls = (funct == FN_JR) ? CLS_JR : CLS_RTYPE;
            OP_LOAD:  cls = CLS_LOAD;
            OP_STORE: cls = CLS_STORE;
            OP_BEQ:   cls = CLS_BEQ;
            OP_BNE:   cls = CLS_BNE;
            OP_J:     cls = CLS_J;
            OP_JAL:   cls = CLS_JAL;
            OP_LUI:   cls = CLS_LUI;
            default:  cls = CLS_OTHER;
         endcase
      end
   end

   // Listed functs win over the zero word; the zero word wins over sll
   always_comb begin
      priority if (funct == FN_ADD) alu = ALU_ADD;
      else if (funct == FN_SUB)     alu = ALU_SUB;
      else if (funct == FN_OR)      alu = ALU_OR;
      else if (funct == FN_SLT)     alu = ALU_SLT;
      else if (funct == FN_AND)     alu = ALU_AND;
      else if (word == '0)          alu = ALU_NOOP;
      else if (funct == FN_SLL)     alu = ALU_SLL;
      else if (funct == FN_SRL)     alu = ALU_SRL;
      else                          alu = ALU_UNKNOWN;
   end

   assign dec.cls     = cls;
   assign dec.alu     = alu;
   assign dec.nonzero = (word != '0);

endmodule

>>> hdl/mshz_hazard.sv
// Read-after-write compare of the later word's sources against the earlier word's destination.
module mshz_hazard (
   input  mshz_pkg::hzd_in_type hzd_in,
   output logic                 hazard
);
   import mshz_pkg::*;

   logic rs_hit;
   logic rt_hit;

   assign rs_hit = hzd_in.reads_rs && (hzd_in.rs == hzd_in.writer_reg);
   assign rt_hit = hzd_in.reads_rt && (hzd_in.rt == hzd_in.writer_reg);
   assign hazard = hzd_in.both_nonzero && hzd_in.writer_valid && (rs_hit || rt_hit);

endmodule
